>>> rtl/core/mebp_pkg.sv
package mebp_pkg;

  localparam int VALUE_W   = 30;
  localparam int FILL_W    = 5;
  localparam int DEPTH_DEF = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_APPLY,
    ST_SHIFT,
    ST_FIN
  } state_t;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  typedef struct packed {
    logic               got_entry;
    logic [VALUE_W-1:0] popped_value;
    logic [FILL_W-1:0]  fill_count;
  } res_t;

endpackage

>>> rtl/core/mebp_mem.sv
module mebp_mem #(
  parameter int DEPTH = mebp_pkg::DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [$clog2(DEPTH)-1:0]     wa,
  input  logic [mebp_pkg::VALUE_W-1:0] wd,
  input  logic                         re,
  input  logic [$clog2(DEPTH)-1:0]     ra,
  output logic [mebp_pkg::VALUE_W-1:0] rd
);
  import mebp_pkg::*;

  logic [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd <= mem[ra];
    end
  end

endmodule

>>> rtl/core/mebp_ctrl.sv
module mebp_ctrl #(
  parameter int DEPTH = mebp_pkg::DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         kind,
  input  logic [mebp_pkg::VALUE_W-1:0] value,
  output logic                         res_valid,
  input  logic                         res_ready,
  output mebp_pkg::res_t               res,
  output logic                         mem_we,
  output logic [$clog2(DEPTH)-1:0]     mem_wa,
  output logic [mebp_pkg::VALUE_W-1:0] mem_wd,
  output logic                         mem_re,
  output logic [$clog2(DEPTH)-1:0]     mem_ra,
  input  logic [mebp_pkg::VALUE_W-1:0] mem_rd
);
  import mebp_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  state_t             state, state_next;
  op_t                op_kind, op_kind_next;
  logic [VALUE_W-1:0] op_value, op_value_next;
  logic [CW-1:0]      count, count_next;
  logic [CW-1:0]      ptr, ptr_next;
  logic [CW-1:0]      limit, limit_next;
  logic               rv, rv_next;
  logic [AW-1:0]      ra, ra_next;
  logic [VALUE_W-1:0] best_val, best_val_next;
  logic [AW-1:0]      best_idx, best_idx_next;
  logic               got, got_next;
  logic [VALUE_W-1:0] popped, popped_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      rv    <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      rv    <= rv_next;
    end
  end

  always_ff @(posedge clk) begin
    op_kind  <= op_kind_next;
    op_value <= op_value_next;
    ptr      <= ptr_next;
    limit    <= limit_next;
    ra       <= ra_next;
    best_val <= best_val_next;
    best_idx <= best_idx_next;
    got      <= got_next;
    popped   <= popped_next;
  end

  always_comb begin
    state_next    = state;
    op_kind_next  = op_kind;
    op_value_next = op_value;
    count_next    = count;
    ptr_next      = ptr;
    limit_next    = limit;
    rv_next       = 1'b0;
    ra_next       = ptr[AW-1:0];
    best_val_next = best_val;
    best_idx_next = best_idx;
    got_next      = got;
    popped_next   = popped;
    in_ready      = 1'b0;
    res_valid     = 1'b0;
    res           = '{got_entry: got, popped_value: popped, fill_count: FILL_W'(count)};
    mem_we        = 1'b0;
    mem_wa        = '0;
    mem_wd        = op_value;
    mem_re        = 1'b0;
    mem_ra        = ptr[AW-1:0];

    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_kind_next  = op_t'(kind);
          op_value_next = value;
          state_next    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ptr_next    = '0;
        got_next    = 1'b0;
        popped_next = '0;
        if (op_kind == OP_PUSH) begin
          if (count < CW'(DEPTH)) begin
            mem_we     = 1'b1;
            mem_wa     = count[AW-1:0];
            count_next = count + CW'(1);
            state_next = ST_FIN;
          end else begin
            limit_next = CW'(DEPTH);
            state_next = ST_SCAN;
          end
        end else if (count == '0) begin
          state_next = ST_FIN;
        end else begin
          limit_next = count;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // one read issued per cycle, compared in the cycle after it is issued
        if (ptr < limit) begin
          mem_re   = 1'b1;
          ptr_next = ptr + CW'(1);
          rv_next  = 1'b1;
        end
        if (rv) begin
          if (ra == '0 || mem_rd < best_val) begin
            best_val_next = mem_rd;
            best_idx_next = ra;
          end
          if (CW'(ra) == limit - CW'(1)) begin
            state_next = ST_APPLY;
          end
        end
      end
      ST_APPLY: begin
        if (op_kind == OP_PUSH) begin
          mem_we     = 1'b1;
          mem_wa     = best_idx;
          state_next = ST_FIN;
        end else begin
          got_next    = 1'b1;
          popped_next = best_val;
          ptr_next    = CW'(best_idx) + CW'(1);
          if (CW'(best_idx) + CW'(1) >= count) begin
            count_next = count - CW'(1);
            state_next = ST_FIN;
          end else begin
            state_next = ST_SHIFT;
          end
        end
      end
      ST_SHIFT: begin
        // read entry k+1, write it to k on the following cycle
        if (ptr < count) begin
          mem_re   = 1'b1;
          ptr_next = ptr + CW'(1);
          rv_next  = 1'b1;
        end
        if (rv) begin
          mem_we = 1'b1;
          mem_wa = ra - AW'(1);
          mem_wd = mem_rd;
          if (CW'(ra) == count - CW'(1)) begin
            count_next = count - CW'(1);
            state_next = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/min_extract_buffer_pool_unit.sv
// Bounded min store of buffer numbers, DEPTH entries in arrival order.
// Input channel (in_valid/in_ready, kind, value): kind 0 pushes value,
// kind 1 pops the first smallest entry. Each request yields one result
// on the output channel (out_valid/out_ready): got_entry, popped_value
// and fill_count after the operation.
// One request at a time; in_ready is high only while the sequencer idles.
// Entries sit in a single-port-write, single-port-read memory with a
// registered read, so a full scan for the minimum reads every entry in
// turn. A push with room writes directly at the end of the store, and a
// pop of an empty store goes straight to the result; a push on a full
// store scans all DEPTH entries and overwrites the first smallest; a pop
// scans count entries, then moves each later entry down one place.
// Results land in an output register; a new request is taken while it
// waits. If the receiver stalls, the finished next result holds in the
// sequencer until the register frees.
// Reset clears the count and all handshake state; no clearing pass.
module min_extract_buffer_pool_unit #(
  parameter int DEPTH = mebp_pkg::DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         kind,
  input  logic [mebp_pkg::VALUE_W-1:0] value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         got_entry,
  output logic [mebp_pkg::VALUE_W-1:0] popped_value,
  output logic [mebp_pkg::FILL_W-1:0]  fill_count
);
  import mebp_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic               res_valid;
  logic               res_ready;
  res_t               res;
  logic               mem_we;
  logic [AW-1:0]      mem_wa;
  logic [VALUE_W-1:0] mem_wd;
  logic               mem_re;
  logic [AW-1:0]      mem_ra;
  logic [VALUE_W-1:0] mem_rd;

  mebp_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .value     (value),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_wa    (mem_wa),
    .mem_wd    (mem_wd),
    .mem_re    (mem_re),
    .mem_ra    (mem_ra),
    .mem_rd    (mem_rd)
  );

  mebp_mem #(.DEPTH(DEPTH)) u_mem (
    .clk (clk),
    .we  (mem_we),
    .wa  (mem_wa),
    .wd  (mem_wd),
    .re  (mem_re),
    .ra  (mem_ra),
    .rd  (mem_rd)
  );

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      got_entry    <= res.got_entry;
      popped_value <= res.popped_value;
      fill_count   <= res.fill_count;
    end
  end

endmodule

>>> tb/mebp_min_store_checker.sv
`timescale 1ns / 100ps

module mebp_min_store_checker #(
  parameter int DEPTH = mebp_pkg::DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic                         kind,
  input  logic [mebp_pkg::VALUE_W-1:0] value,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic                         got_entry,
  input  logic [mebp_pkg::VALUE_W-1:0] popped_value,
  input  logic [mebp_pkg::FILL_W-1:0]  fill_count,
  output int                           errors,
  output int                           pending_results
);
  import mebp_pkg::*;

  logic [VALUE_W-1:0] pool_vals [DEPTH];
  int unsigned        pool_count;
  res_t               expected_results [$];

  // first (lowest index) smallest among the first n entries
  function automatic int unsigned first_min(int unsigned n);
    int unsigned best;
    best = 0;
    for (int unsigned k = 1; k < n; k++) begin
      if (pool_vals[k] < pool_vals[best]) begin
        best = k;
      end
    end
    return best;
  endfunction

  function automatic res_t apply_request(op_t op, logic [VALUE_W-1:0] v);
    res_t        r;
    int unsigned idx;
    r = '0;
    if (op == OP_PUSH) begin
      if (pool_count >= DEPTH) begin
        pool_vals[first_min(DEPTH)] = v;
      end else begin
        pool_vals[pool_count] = v;
        pool_count++;
      end
    end else if (pool_count > 0) begin
      idx = first_min(pool_count);
      r.got_entry    = 1'b1;
      r.popped_value = pool_vals[idx];
      for (int unsigned k = idx; k + 1 < pool_count; k++) begin
        pool_vals[k] = pool_vals[k + 1];
      end
      pool_count--;
    end
    r.fill_count = FILL_W'(pool_count);
    return r;
  endfunction

  initial begin
    errors          = 0;
    pending_results = 0;
    pool_count      = 0;
  end

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      pool_count = 0;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result got_entry=%0b popped_value=%0d fill_count=%0d",
                   $time, got_entry, popped_value, fill_count);
        end else begin
          want = expected_results.pop_front();
          if (got_entry !== want.got_entry) begin
            errors++;
            $display("%0t: got_entry expected %0b actual %0b",
                     $time, want.got_entry, got_entry);
          end
          if (popped_value !== want.popped_value) begin
            errors++;
            $display("%0t: popped_value expected %0d actual %0d",
                     $time, want.popped_value, popped_value);
          end
          if (fill_count !== want.fill_count) begin
            errors++;
            $display("%0t: fill_count expected %0d actual %0d",
                     $time, want.fill_count, fill_count);
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(apply_request(op_t'(kind), value));
      end
    end
    pending_results = expected_results.size();
  end

endmodule

>>> tb/min_extract_buffer_pool_unit_tb.sv
`timescale 1ns / 100ps

module min_extract_buffer_pool_unit_tb;
  import mebp_pkg::*;

  localparam int DEPTH        = DEPTH_DEF;
  localparam int RANDOM_ITEMS = 1500;
  localparam int CYCLE_LIMIT  = 400000;

  typedef enum int {
    VAL_WIDE,
    VAL_TIES,
    VAL_TOP,
    VAL_SENTINEL
  } val_mode_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic               kind;
  logic [VALUE_W-1:0] value;
  logic               out_valid;
  logic               out_ready;
  logic               got_entry;
  logic [VALUE_W-1:0] popped_value;
  logic [FILL_W-1:0]  fill_count;
  int                 errors;
  int                 pending_results;
  int                 cycle_count = 0;
  logic               no_idle = 1'b0;

  min_extract_buffer_pool_unit #(
    .DEPTH(DEPTH)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .value       (value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .got_entry   (got_entry),
    .popped_value(popped_value),
    .fill_count  (fill_count)
  );

  mebp_min_store_checker #(
    .DEPTH(DEPTH)
  ) checker_i (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .kind           (kind),
    .value          (value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .got_entry      (got_entry),
    .popped_value   (popped_value),
    .fill_count     (fill_count),
    .errors         (errors),
    .pending_results(pending_results)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("min_extract_buffer_pool_unit verification failed");
      $finish;
    end
  end

  function automatic logic [VALUE_W-1:0] draw_value(val_mode_t mode);
    case (mode)
      VAL_WIDE:     return VALUE_W'($urandom());
      VAL_TIES:     return VALUE_W'($urandom_range(0, 15));
      VAL_TOP:      return {VALUE_W{1'b1}} - VALUE_W'($urandom_range(0, 15));
      default:      return VALUE_W'($urandom_range(999999990, 1000000010));
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(op_t op, logic [VALUE_W-1:0] v);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    kind     <= op;
    value    <= v;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  initial begin
    int unsigned stall;
    out_ready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 13);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    int        sent;
    int        len;
    int        push_pct;
    val_mode_t mode;
    op_t       op;
    rst      = 1'b1;
    in_valid = 1'b0;
    kind     = OP_PUSH;
    value    = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty pops, extremes, tie on the smallest value
    send_request(OP_POP, '0);
    send_request(OP_PUSH, {VALUE_W{1'b1}});
    send_request(OP_PUSH, '0);
    send_request(OP_PUSH, '0);
    repeat (3) send_request(OP_POP, VALUE_W'($urandom()));
    send_request(OP_POP, {VALUE_W{1'b1}});

    // fill with repeated values, then push on a full store
    for (int i = 0; i < DEPTH; i++) begin
      send_request(OP_PUSH, VALUE_W'(100 + (i * 7) % 5));
    end
    send_request(OP_PUSH, VALUE_W'(1000000000));
    send_request(OP_PUSH, {VALUE_W{1'b1}});

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 2))
        0:       push_pct = 15;
        1:       push_pct = 50;
        default: push_pct = 85;
      endcase
      mode    = val_mode_t'($urandom_range(0, 3));
      no_idle = ($urandom_range(0, 3) == 0);
      len     = $urandom_range(10, 60);
      for (int i = 0; i < len; i++) begin
        op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
        send_request(op, draw_value(mode));
      end
      sent += len;
    end
    in_valid <= 1'b0;
    no_idle  = 1'b0;

    while (pending_results != 0) @(posedge clk);
    repeat (2 * DEPTH + 20) @(posedge clk);
    if (errors == 0) begin
      $display("min_extract_buffer_pool_unit verification clean");
    end else begin
      $display("min_extract_buffer_pool_unit verification failed");
    end
    $finish;
  end

endmodule
